// ===== rtl/pbc_pkg.sv =====
// Shared types and constants for the per-key Bezier response curve unit.
// No dependencies; imported by every module of the block.
package pbc_pkg;

    localparam int KEY_COUNT = 64;
    localparam int KEY_AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam logic [1:0] MODE_APPLY   = 2'd0;
    localparam logic [1:0] MODE_HEIGHTS = 2'd1;
    localparam logic [1:0] MODE_ENABLE  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key;
        logic [7:0] level;
        logic [7:0] first_height;
        logic [7:0] second_height;
        logic       enable;
    } pbc_in_t;

    typedef struct packed {
        logic [7:0] mapped;
        logic       accepted;
    } pbc_out_t;

    // One table entry: enable flag and both control heights
    typedef struct packed {
        logic       enable;
        logic [7:0] second_height;
        logic [7:0] first_height;
    } pbc_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [KEY_AW-1:0] wr_addr;
        pbc_entry_t        wr_entry;
    } pbc_wr_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] first_height;
        logic [7:0] second_height;
    } pbc_curve_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CURVE,
        ST_DONE
    } pbc_state_t;

endpackage

// ===== rtl/pbc_table.sv =====
// Per-key curve table: one synchronous memory with a registered read port.
// Depends on pbc_pkg. Per-entry valid bits make unwritten entries read as zero.
module pbc_table (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pbc_pkg::KEY_AW-1:0] rd_addr,
    output pbc_pkg::pbc_entry_t        rd_entry,
    input  pbc_pkg::pbc_wr_t           wr
);
    import pbc_pkg::*;

    pbc_entry_t            mem [KEY_COUNT];
    logic [KEY_COUNT-1:0]  valid_reg;
    pbc_entry_t            rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            mem[wr.wr_addr] <= wr.wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.wr_en) begin
                valid_reg[wr.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/pbc_curve.sv =====
// Four-stage cubic Bezier evaluator, end points 0 and 255, 8 fractional bits.
// Depends on pbc_pkg. The done flag rises together with the result.
module pbc_curve (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  pbc_pkg::pbc_curve_req_t req,
    output logic                   done,
    output logic [7:0]             value
);
    import pbc_pkg::*;

    logic [8:0]  t_in;
    logic [8:0]  u_in;
    logic [17:0] tt_prod;
    logic [17:0] uu_prod;

    logic [8:0]  t1_reg, u1_reg, t2_reg, u2_reg;
    logic [7:0]  h1_s1_reg, h2_s1_reg, h1_s2_reg, h2_s2_reg;
    logic        v1_reg, v2_reg, v3_reg, done_reg;

    logic [17:0] t3_prod, a_prod, b_prod;
    logic [8:0]  t3_reg, a_reg, b_reg;

    logic [10:0] a3, b3;
    logic [18:0] p1, p2;
    logic [16:0] p3;
    logic [10:0] term1_reg, term2_reg;
    logic [8:0]  term3_reg;

    logic [11:0] sum;
    logic [7:0]  value_reg;

    // (level << 8) / 255 equals level, plus one at full scale
    assign t_in    = {1'b0, req.level} + 9'(req.level == 8'hFF);
    assign u_in    = 9'd256 - t_in;
    assign tt_prod = 18'(t_in) * 18'(t_in);
    assign uu_prod = 18'(u_in) * 18'(u_in);

    assign t3_prod = 18'(t2_reg) * 18'(t1_reg);
    assign a_prod  = 18'(u2_reg) * 18'(t1_reg);
    assign b_prod  = 18'(u1_reg) * 18'(t2_reg);

    assign a3 = 11'(a_reg) + {1'b0, a_reg, 1'b0};
    assign b3 = 11'(b_reg) + {1'b0, b_reg, 1'b0};
    assign p1 = 19'(a3) * 19'(h1_s2_reg);
    assign p2 = 19'(b3) * 19'(h2_s2_reg);
    assign p3 = {t3_reg, 8'd0} - 17'(t3_reg);   // t3 * 255

    assign sum = 12'(term1_reg) + 12'(term2_reg) + 12'(term3_reg);

    always_ff @(posedge aclk) begin
        t1_reg    <= t_in;
        u1_reg    <= u_in;
        t2_reg    <= tt_prod[16:8];
        u2_reg    <= uu_prod[16:8];
        h1_s1_reg <= req.first_height;
        h2_s1_reg <= req.second_height;

        t3_reg    <= t3_prod[16:8];
        a_reg     <= a_prod[16:8];
        b_reg     <= b_prod[16:8];
        h1_s2_reg <= h1_s1_reg;
        h2_s2_reg <= h2_s1_reg;

        term1_reg <= p1[18:8];
        term2_reg <= p2[18:8];
        term3_reg <= p3[16:8];

        value_reg <= (sum > 12'd255) ? 8'hFF : sum[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// ===== rtl/per_key_bezier_response_curve_unit.sv =====
// Per-key Bezier response curve: each beat either stores a key's control heights,
// stores its curve enable, or maps a travel level through that key's cubic curve;
// every beat returns exactly one result beat. Write beats and pass-through applies
// (key out of range or curve disabled) go from the table read straight to the result
// handoff; an apply on an enabled key runs the four-stage curve pipeline in between.
// A new beat is taken while an earlier result still waits on m_ready. The table
// resets to all zero through per-entry valid bits; no clearing pass is needed.
// Depends on pbc_pkg, pbc_table and pbc_curve.
module per_key_bezier_response_curve_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pbc_pkg::pbc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pbc_pkg::pbc_out_t m_data
);
    import pbc_pkg::*;

    pbc_state_t     state_reg, state_next;
    pbc_in_t        item_reg;
    pbc_out_t       res_reg, res_next;
    pbc_out_t       m_data_reg;
    logic           m_valid_reg, m_valid_next;
    logic           load_out;

    pbc_entry_t     rd_entry;
    pbc_wr_t        wr;
    logic           key_ok;
    logic           curve_start;
    pbc_curve_req_t curve_req;
    logic           curve_done;
    logic [7:0]     curve_value;

    pbc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (s_data.key[KEY_AW-1:0]),
        .rd_entry(rd_entry),
        .wr      (wr)
    );

    pbc_curve u_curve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (curve_start),
        .req     (curve_req),
        .done    (curve_done),
        .value   (curve_value)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign key_ok  = ({1'b0, item_reg.key} < 9'(KEY_COUNT));

    assign curve_req.level         = item_reg.level;
    assign curve_req.first_height  = rd_entry.first_height;
    assign curve_req.second_height = rd_entry.second_height;

    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        curve_start = 1'b0;
        load_out    = 1'b0;
        wr.wr_en    = 1'b0;
        wr.wr_addr  = item_reg.key[KEY_AW-1:0];
        wr.wr_entry = rd_entry;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                res_next.mapped   = 8'd0;
                res_next.accepted = 1'b0;
                state_next        = ST_DONE;
                unique case (item_reg.mode)
                    MODE_APPLY: begin
                        res_next.mapped   = item_reg.level;
                        res_next.accepted = key_ok;
                        if (key_ok && rd_entry.enable) begin
                            curve_start = 1'b1;
                            state_next  = ST_CURVE;
                        end
                    end
                    MODE_HEIGHTS: begin
                        res_next.accepted         = key_ok;
                        wr.wr_en                  = key_ok;
                        wr.wr_entry.first_height  = item_reg.first_height;
                        wr.wr_entry.second_height = item_reg.second_height;
                    end
                    MODE_ENABLE: begin
                        res_next.accepted  = key_ok;
                        wr.wr_en           = key_ok;
                        wr.wr_entry.enable = item_reg.enable;
                    end
                    default: begin
                        // unused mode: nothing stored, rejected
                    end
                endcase
            end
            ST_CURVE: begin
                if (curve_done) begin
                    res_next.mapped = curve_value;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        res_reg <= res_next;
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/pbc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the per-key Bezier curve unit: watches both channels, keeps its
// own copy of the key tables, predicts each result beat and compares it in order.
// Depends on pbc_pkg.
module pbc_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pbc_pkg::pbc_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  pbc_pkg::pbc_out_t m_data,
    output int                fail_count,
    output int                pending
);
    import pbc_pkg::*;

    logic [7:0] first_tab  [KEY_COUNT];
    logic [7:0] second_tab [KEY_COUNT];
    logic       enable_tab [KEY_COUNT];

    pbc_out_t expected_q[$];

    // Fixed-point cubic with end points 0 and 255; every product keeps 8 fraction bits
    function automatic logic [7:0] bezier_level(input logic [7:0] lvl,
                                                input logic [7:0] h1,
                                                input logic [7:0] h2);
        logic [31:0] t, t2, t3, u, u2, term_a, term_b, term_c, total;
        t      = ({24'd0, lvl} << 8) / 32'd255;
        t2     = (t * t) >> 8;
        t3     = (t2 * t) >> 8;
        u      = 32'd256 - t;
        u2     = (u * u) >> 8;
        term_a = (32'd3 * ((u2 * t) >> 8) * {24'd0, h1}) >> 8;
        term_b = (32'd3 * ((u * t2) >> 8) * {24'd0, h2}) >> 8;
        term_c = (t3 * 32'd255) >> 8;
        total  = term_a + term_b + term_c;
        return (total > 32'd255) ? 8'hFF : total[7:0];
    endfunction

    // Updates the tables and returns the result beat this input beat should produce
    function automatic pbc_out_t map_beat(input pbc_in_t beat);
        pbc_out_t res;
        logic     in_range;
        int       idx;
        in_range     = (int'(beat.key) < KEY_COUNT);
        idx          = int'(beat.key);
        res.mapped   = 8'd0;
        res.accepted = 1'b0;
        case (beat.mode)
            MODE_APPLY: begin
                res.mapped = beat.level;
                if (in_range) begin
                    res.accepted = 1'b1;
                    if (enable_tab[idx])
                        res.mapped = bezier_level(beat.level, first_tab[idx],
                                                  second_tab[idx]);
                end
            end
            MODE_HEIGHTS: begin
                if (in_range) begin
                    first_tab[idx]  = beat.first_height;
                    second_tab[idx] = beat.second_height;
                    res.accepted    = 1'b1;
                end
            end
            MODE_ENABLE: begin
                if (in_range) begin
                    enable_tab[idx] = beat.enable;
                    res.accepted    = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    assign pending = expected_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        pbc_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                first_tab[i]  = 8'd0;
                second_tab[i] = 8'd0;
                enable_tab[i] = 1'b0;
            end
            expected_q.delete();
        end else begin
            // result side first: a beat leaving now always belongs to an older input
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: mapped %0d accepted %0b",
                           m_data.mapped, m_data.accepted);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.mapped !== want.mapped) begin
                        $error("mapped: expected %0d, got %0d", want.mapped, m_data.mapped);
                        fail_count++;
                    end
                    if (m_data.accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b",
                               want.accepted, m_data.accepted);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(map_beat(s_data));
        end
    end

endmodule

// ===== tb/per_key_bezier_response_curve_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the curve unit testbench: clock, reset, directed and random beats,
// throttling of both channels and the verdict. Depends on pbc_pkg and pbc_checker.
module per_key_bezier_response_curve_unit_tb;
    import pbc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         LONG_HOLD   = 400;
    localparam int         PHASE_BEATS = 400;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pbc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    pbc_out_t m_data;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    logic long_hold;

    per_key_bezier_response_curve_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pbc_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int hold_left;
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pbc_in_t make_beat(input logic [1:0] mode, input logic [7:0] key,
                                          input logic [7:0] level, input logic [7:0] h1,
                                          input logic [7:0] h2, input logic en);
        pbc_in_t beat;
        beat.mode          = mode;
        beat.key           = key;
        beat.level         = level;
        beat.first_height  = h1;
        beat.second_height = h2;
        beat.enable        = en;
        return beat;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the beat or after a gap
    task automatic send_beat(input pbc_in_t beat);
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // each free cycle is idle with the phase's probability
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        pbc_in_t beat;
        int      pick;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (PHASE_BEATS) begin
            pick               = $urandom_range(99);
            beat.level         = 8'($urandom_range(255));
            beat.first_height  = 8'($urandom_range(255));
            beat.second_height = 8'($urandom_range(255));
            beat.enable        = ($urandom_range(99) < 75);
            if ($urandom_range(9) == 0)
                beat.key = 8'($urandom_range(255, KEY_COUNT));
            else
                beat.key = 8'($urandom_range(KEY_COUNT - 1));
            if (pick < 48)
                beat.mode = MODE_APPLY;
            else if (pick < 72)
                beat.mode = MODE_HEIGHTS;
            else if (pick < 94)
                beat.mode = MODE_ENABLE;
            else
                beat.mode = MODE_UNUSED;
            if ($urandom_range(19) == 0)
                beat.level = $urandom_range(1) ? 8'hFF : 8'h00;
            send_beat(beat);
        end
        drain();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        long_hold       = 1'b0;
        quiet_cycles    = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // after reset every key is disabled: applies pass the level through
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd0,   8'hFF, 8'hFF, 1'b1));
        send_beat(make_beat(MODE_APPLY,   8'd63,  8'd255, 8'h00, 8'h00, 1'b0));
        // out-of-range keys and unused modes
        send_beat(make_beat(MODE_APPLY,   8'd64,  8'd77,  8'h12, 8'h34, 1'b1));
        send_beat(make_beat(MODE_APPLY,   8'd255, 8'd255, 8'hFF, 8'hFF, 1'b1));
        send_beat(make_beat(MODE_HEIGHTS, 8'd64,  8'd10,  8'hFF, 8'hFF, 1'b1));
        send_beat(make_beat(MODE_ENABLE,  8'd200, 8'd10,  8'h00, 8'h00, 1'b1));
        send_beat(make_beat(MODE_UNUSED,  8'd5,   8'hFF,  8'hFF, 8'hFF, 1'b1));
        send_beat(make_beat(MODE_UNUSED,  8'd255, 8'h00,  8'h00, 8'h00, 1'b0));
        // full-height curve on key 0
        send_beat(make_beat(MODE_HEIGHTS, 8'd0,   8'd0,   8'hFF, 8'hFF, 1'b0));
        send_beat(make_beat(MODE_ENABLE,  8'd0,   8'd0,   8'h00, 8'h00, 1'b1));
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd0,   8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd255, 8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd128, 8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd200, 8'h00, 8'h00, 1'b0));
        // last key and key 1, asymmetric heights
        send_beat(make_beat(MODE_HEIGHTS, 8'd63,  8'd0,   8'h00, 8'hFF, 1'b1));
        send_beat(make_beat(MODE_ENABLE,  8'd63,  8'd0,   8'h00, 8'h00, 1'b1));
        send_beat(make_beat(MODE_APPLY,   8'd63,  8'd1,   8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_APPLY,   8'd63,  8'd254, 8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_HEIGHTS, 8'd1,   8'd0,   8'h55, 8'hAA, 1'b0));
        send_beat(make_beat(MODE_ENABLE,  8'd1,   8'd0,   8'h00, 8'h00, 1'b1));
        send_beat(make_beat(MODE_APPLY,   8'd1,   8'd100, 8'h00, 8'h00, 1'b0));
        // disabling again restores pass-through
        send_beat(make_beat(MODE_ENABLE,  8'd0,   8'd0,   8'h00, 8'h00, 1'b0));
        send_beat(make_beat(MODE_APPLY,   8'd0,   8'd100, 8'h00, 8'h00, 1'b0));
        drain();

        long_hold = 1'b1;   // receiver blocks while the sender keeps pushing
        run_phase(0, 0);
        run_phase(52, 0);
        run_phase(0, 52);
        run_phase(17, 17);

        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
